### rtl/core/ypcb_pkg.sv
package ypcb_pkg;

	localparam int CordicSteps = 16;
	localparam int VecFracBits = 14;
	localparam int StepW = 5;

	localparam logic signed [16:0] YawHalf = 17'sd23040;
	localparam logic signed [16:0] YawSpan = 17'sd46080;
	localparam logic signed [15:0] PitchLim = 16'sd11392;
	localparam logic signed [34:0] Deg90 = 35'sd5898240;
	localparam logic signed [34:0] Deg180 = 35'sd11796480;
	localparam logic signed [33:0] QOne = 34'sd1073741824;

	localparam logic [2:0] RegMoveSpeed = 3'd0;
	localparam logic [2:0] RegTurnSpeed = 3'd1;
	localparam logic [2:0] RegUpX = 3'd2;
	localparam logic [2:0] RegUpY = 3'd3;
	localparam logic [2:0] RegUpZ = 3'd4;
	localparam logic [2:0] RegStartYaw = 3'd5;
	localparam logic [2:0] RegStartPitch = 3'd6;

	localparam logic OpMove = 1'b0;
	localparam logic OpTurn = 1'b1;

	typedef struct packed {
		logic               op;
		logic [5:0]         key_mask;
		logic [15:0]        delta_time;
		logic signed [15:0] turn_x;
		logic signed [15:0] turn_y;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] fwd_x;
		logic signed [15:0] fwd_y;
		logic signed [15:0] fwd_z;
		logic signed [15:0] side_x;
		logic signed [15:0] side_y;
		logic signed [15:0] side_z;
		logic signed [15:0] upward_x;
		logic signed [15:0] upward_y;
		logic signed [15:0] upward_z;
	} rsp_t;

	function automatic logic signed [34:0] atan_entry(input logic [StepW-1:0] i);
		logic signed [34:0] r;
		unique case (i)
			5'd0: r = 35'sd2949120;
			5'd1: r = 35'sd1740967;
			5'd2: r = 35'sd919879;
			5'd3: r = 35'sd466945;
			5'd4: r = 35'sd234379;
			5'd5: r = 35'sd117304;
			5'd6: r = 35'sd58666;
			5'd7: r = 35'sd29335;
			5'd8: r = 35'sd14668;
			5'd9: r = 35'sd7334;
			5'd10: r = 35'sd3667;
			5'd11: r = 35'sd1833;
			5'd12: r = 35'sd917;
			5'd13: r = 35'sd458;
			5'd14: r = 35'sd229;
			5'd15: r = 35'sd115;
			5'd16: r = 35'sd57;
			5'd17: r = 35'sd29;
			5'd18: r = 35'sd14;
			5'd19: r = 35'sd7;
			5'd20: r = 35'sd4;
			5'd21: r = 35'sd2;
			5'd22: r = 35'sd1;
			default: r = 35'sd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/ypcb_if.sv
interface ypcb_req_if;
	import ypcb_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ypcb_rsp_if;
	import ypcb_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ypcb_cordic.sv
module ypcb_cordic import ypcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] ang,
	output logic               done,
	output logic signed [33:0] cos_out,
	output logic signed [33:0] sin_out
);
	logic               busy_q;
	logic [StepW-1:0]   i_q;
	logic signed [34:0] x_q, y_q, z_q;
	logic               neg_q;
	logic signed [34:0] z0;
	logic signed [34:0] dx, dy;

	always_comb begin
		z0 = 35'(ang) <<< 9;
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
	end

	assign cos_out = neg_q ? -34'(x_q) : 34'(x_q);
	assign sin_out = neg_q ? -34'(y_q) : 34'(y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				x_q <= 35'(QOne);
				y_q <= '0;
				neg_q <= (z0 > Deg90) || (z0 < -Deg90);
				if (z0 > Deg90) z_q <= z0 - Deg180;
				else if (z0 < -Deg90) z_q <= z0 + Deg180;
				else z_q <= z0;
			end else if (busy_q) begin
				if (!z_q[34]) begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_entry(i_q);
				end else begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_entry(i_q);
				end
				i_q <= i_q + 1'b1;
				if (i_q == StepW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

### rtl/core/ypcb_norm.sv
module ypcb_norm import ypcb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] vx,
	input  logic signed [33:0] vy,
	input  logic signed [33:0] vz,
	output logic               done,
	output logic signed [15:0] ox,
	output logic signed [15:0] oy,
	output logic signed [15:0] oz
);
	typedef enum logic [4:0] {
		N_IDLE = 5'b00001, N_SQ = 5'b00010, N_ROOT = 5'b00100,
		N_DIV = 5'b01000, N_OUT = 5'b10000
	} nst_t;

	nst_t               st_q;
	logic [32:0]        mag_q [3];
	logic               sgn_q [3];
	logic [1:0]         k_q;
	logic [5:0]         cnt_q;
	logic [67:0]        acc_q;
	logic [67:0]        rem_q;
	logic [33:0]        root_q;
	logic [47:0]        num_q;
	logic [47:0]        quo_q;
	logic [34:0]        drem_q;
	logic signed [15:0] res_q [3];

	logic [65:0] sq;
	logic [69:0] trial;
	logic [69:0] rem_sh;
	logic [35:0] dtrial;
	logic [15:0] sat;

	always_comb begin
		sq = 66'(mag_q[k_q]) * 66'(mag_q[k_q]);
		rem_sh = {rem_q, acc_q[67:66]};
		trial = {34'd0, root_q, 2'b01};
		dtrial = {drem_q, num_q[47]} - {2'b0, root_q};
		sat = (quo_q > 48'd32767) ? 16'd32767 : quo_q[15:0];
	end

	assign ox = res_q[0];
	assign oy = res_q[1];
	assign oz = res_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				N_IDLE: if (start) begin
					mag_q[0] <= vx[33] ? 33'(-vx) : 33'(vx);
					mag_q[1] <= vy[33] ? 33'(-vy) : 33'(vy);
					mag_q[2] <= vz[33] ? 33'(-vz) : 33'(vz);
					sgn_q[0] <= vx[33]; sgn_q[1] <= vy[33]; sgn_q[2] <= vz[33];
					k_q <= '0; acc_q <= '0;
					st_q <= N_SQ;
				end
				N_SQ: begin
					acc_q <= acc_q + 68'(sq);
					if (k_q == 2'd2) begin
						st_q <= N_ROOT; cnt_q <= '0; rem_q <= '0; root_q <= '0;
					end else k_q <= k_q + 1'b1;
				end
				N_ROOT: begin
					// one result bit per cycle, two radicand bits
					acc_q <= acc_q << 2;
					if (rem_sh >= trial) begin
						rem_q <= 68'(rem_sh - trial);
						root_q <= {root_q[32:0], 1'b1};
					end else begin
						rem_q <= 68'(rem_sh);
						root_q <= {root_q[32:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd33) begin
						st_q <= N_DIV; k_q <= '0; cnt_q <= '0;
					end
				end
				N_DIV: begin
					if (cnt_q == 6'd0) begin
						num_q <= (48'(mag_q[k_q]) << VecFracBits) + 48'(root_q >> 1);
						quo_q <= '0; drem_q <= '0;
						cnt_q <= 6'd1;
					end else if (cnt_q <= 6'd48) begin
						num_q <= num_q << 1;
						if (!dtrial[35]) begin
							drem_q <= dtrial[34:0];
							quo_q <= {quo_q[46:0], 1'b1};
						end else begin
							drem_q <= {drem_q[33:0], num_q[47]};
							quo_q <= {quo_q[46:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
					end else begin
						if (root_q == '0) res_q[k_q] <= '0;
						else res_q[k_q] <= sgn_q[k_q] ? -$signed(sat) : $signed(sat);
						cnt_q <= '0;
						if (k_q == 2'd2) st_q <= N_OUT;
						else k_q <= k_q + 1'b1;
					end
				end
				N_OUT: begin
					done <= 1'b1;
					st_q <= N_IDLE;
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/yaw_pitch_camera_basis_top.sv
// Turn request: from accept the block wraps the heading, runs the CORDIC for gain, yaw and
// pitch, forms 3 forward products and 3 normalise passes in ypcb_norm, then responds.
// Move request: each held key is applied to the position one component per cycle.
// One request at a time; a new request is taken while the last response waits to be taken.
// After reset the basis is built from the fixed reset angles, with no request taken.
// arst_n resets position, angles, settings and control state asynchronously.
module yaw_pitch_camera_basis_top import ypcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata,
	ypcb_req_if.sink    req,
	ypcb_rsp_if.source  rsp
);
	typedef enum logic [10:0] {
		S_TURN = 11'h001, S_COR = 11'h002, S_FWD = 11'h004,
		S_NF = 11'h008, S_SIDE = 11'h010, S_NU = 11'h020,
		S_IDLE = 11'h040, S_MOVE = 11'h080, S_RSP = 11'h100,
		S_MUL = 11'h200, S_WRAP = 11'h400
	} st_t;

	st_t                st_q;
	logic [15:0]        move_speed_q, turn_speed_q;
	logic signed [15:0] up_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [15:0] yaw_q, pitch_q;
	logic signed [15:0] fwd_q [3], side_q [3], upv_q [3];
	logic signed [33:0] cs_q [5];   // gain, cos yaw, sin yaw, cos pitch, sin pitch
	logic [1:0]         ang_q;
	logic [1:0]         k_q;
	logic [2:0]         key_q;
	logic [5:0]         keys_q;
	logic [31:0]        vel_q;
	logic               first_q;
	logic signed [33:0] raw_q [3];
	logic               nsel_q;   // low: side pass, high: up pass
	logic               pend_q;   // high while a request is being served
	logic [28:0]        wrap_q;
	logic [3:0]         sh_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               cor_start, cor_done, n_start, n_done;
	logic signed [15:0] cor_ang;
	logic signed [33:0] cor_c, cor_s, n_x, n_y, n_z;
	logic signed [15:0] n_ox, n_oy, n_oz;

	// shared signed 34 x 34 multiplier: drives basis products and move scaling
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic signed [48:0] dmov;
	logic signed [33:0] dirv;
	logic signed [33:0] psum;
	logic signed [28:0] ysum, pfull;
	logic [28:0]        wsub, wnext;
	logic signed [16:0] ywrap;
	logic signed [32:0] tx, ty;

	ypcb_cordic u_cordic (.clk, .arst_n, .start(cor_start), .ang(cor_ang),
		.done(cor_done), .cos_out(cor_c), .sin_out(cor_s));
	ypcb_norm u_norm (.clk, .arst_n, .start(n_start), .vx(n_x), .vy(n_y), .vz(n_z),
		.done(n_done), .ox(n_ox), .oy(n_oy), .oz(n_oz));

	always_comb begin
		unique case (ang_q)
			2'd0: cor_ang = '0;
			2'd1: cor_ang = yaw_q;
			default: cor_ang = pitch_q;
		endcase
		// raw forward first, then cross products: fwd x up for side, side x fwd for up
		if (st_q == S_NF) begin
			n_x = raw_q[0];
			n_y = raw_q[1];
			n_z = raw_q[2];
		end else if (!nsel_q) begin
			n_x = 34'(fwd_q[1]) * 34'(up_q[2]) - 34'(fwd_q[2]) * 34'(up_q[1]);
			n_y = 34'(fwd_q[2]) * 34'(up_q[0]) - 34'(fwd_q[0]) * 34'(up_q[2]);
			n_z = 34'(fwd_q[0]) * 34'(up_q[1]) - 34'(fwd_q[1]) * 34'(up_q[0]);
		end else begin
			n_x = 34'(side_q[1]) * 34'(fwd_q[2]) - 34'(side_q[2]) * 34'(fwd_q[1]);
			n_y = 34'(side_q[2]) * 34'(fwd_q[0]) - 34'(side_q[0]) * 34'(fwd_q[2]);
			n_z = 34'(side_q[0]) * 34'(fwd_q[1]) - 34'(side_q[1]) * 34'(fwd_q[0]);
		end
		unique case (key_q)
			3'd0, 3'd1: dirv = 34'(fwd_q[k_q]);
			3'd2, 3'd3: dirv = 34'(side_q[k_q]);
			default: dirv = 34'(up_q[k_q]);
		endcase
		if (st_q == S_FWD) begin
			unique case (k_q)
				2'd0: begin ma = cs_q[1]; mb = cs_q[3]; end
				2'd1: begin ma = cs_q[4]; mb = cs_q[0]; end
				default: begin ma = cs_q[2]; mb = cs_q[3]; end
			endcase
		end else begin
			ma = dirv;
			mb = 34'($signed({1'b0, vel_q}));
		end
		prod = ma * mb;
		dmov = 49'((prod + (68'sd1 <<< (VecFracBits + 7))) >>> (VecFracBits + 8));
		if (key_q[0] == ((key_q == 3'd2) || (key_q == 3'd3)))
			psum = 34'(pos_q[k_q]) + 34'(dmov);
		else
			psum = 34'(pos_q[k_q]) - 34'(dmov);
		tx = 33'(req.data.turn_x) * 33'($signed({1'b0, turn_speed_q}));
		ty = 33'(req.data.turn_y) * 33'($signed({1'b0, turn_speed_q}));
		// offset the new heading into a positive range below 46080 << 12
		ysum = 29'(yaw_q) + 29'((tx + 33'sd16) >>> 5) + 29'(YawHalf) + (29'(YawSpan) <<< 11);
		pfull = 29'(pitch_q) + 29'((ty + 33'sd16) >>> 5);
		wsub = 29'(YawSpan) << sh_q;
		wnext = (wrap_q >= wsub) ? wrap_q - wsub : wrap_q;
		ywrap = $signed(17'(wnext)) - YawHalf;
	end

	assign cor_start = (st_q == S_TURN);
	assign n_start = ((st_q == S_NF) || (st_q == S_SIDE)) && first_q;
	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_TURN;
			move_speed_q <= 16'd1280;
			turn_speed_q <= 16'd4096;
			up_q[0] <= '0; up_q[1] <= 16'sd16384; up_q[2] <= '0;
			pos_q[0] <= '0; pos_q[1] <= '0; pos_q[2] <= '0;
			yaw_q <= -16'sd11520;
			pitch_q <= '0;
			ang_q <= '0; k_q <= '0; key_q <= '0;
			first_q <= 1'b0;
			nsel_q <= 1'b0;
			pend_q <= 1'b0;
			sh_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					RegMoveSpeed: move_speed_q <= cfg_wdata;
					RegTurnSpeed: turn_speed_q <= cfg_wdata;
					RegUpX: up_q[0] <= cfg_wdata;
					RegUpY: up_q[1] <= cfg_wdata;
					RegUpZ: up_q[2] <= cfg_wdata;
					// start angle writes are ignored; reset uses fixed angles
					RegStartYaw: ;
					RegStartPitch: ;
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready && st_q != S_RSP) rsp_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (req.valid) begin
					pend_q <= 1'b1;
					if (req.data.op == OpTurn) begin
						wrap_q <= ysum;
						sh_q <= 4'd11;
						pitch_q <= (pfull >= 29'(PitchLim)) ? PitchLim :
							((pfull <= -29'(PitchLim)) ? -PitchLim : pfull[15:0]);
						st_q <= S_WRAP;
					end else begin
						keys_q <= req.data.key_mask;
						vel_q <= 32'(move_speed_q) * 32'(req.data.delta_time);
						key_q <= '0; k_q <= '0;
						st_q <= S_MUL;
					end
				end
				S_WRAP: begin
					// strip 46080 << n from the heading, n from 11 down to 0
					wrap_q <= wnext;
					sh_q <= sh_q - 1'b1;
					if (sh_q == 4'd0) begin
						yaw_q <= ywrap[15:0];
						ang_q <= '0;
						st_q <= S_TURN;
					end
				end
				S_TURN: begin
					first_q <= 1'b0;
					st_q <= S_COR;
				end
				S_COR: if (cor_done) begin
					if (ang_q == 2'd0) begin cs_q[0] <= cor_c; end
					else if (ang_q == 2'd1) begin cs_q[1] <= cor_c; cs_q[2] <= cor_s; end
					else begin cs_q[3] <= cor_c; cs_q[4] <= cor_s; end
					if (ang_q == 2'd2) begin k_q <= '0; st_q <= S_FWD; end
					else begin ang_q <= ang_q + 1'b1; st_q <= S_TURN; end
				end
				S_FWD: begin
					raw_q[k_q] <= 34'(prod >>> 32);
					if (k_q == 2'd2) begin st_q <= S_NF; first_q <= 1'b1; end
					else k_q <= k_q + 1'b1;
				end
				S_NF: begin
					first_q <= 1'b0;
					if (n_done) begin
						fwd_q[0] <= n_ox; fwd_q[1] <= n_oy; fwd_q[2] <= n_oz;
						nsel_q <= 1'b0; first_q <= 1'b1;
						st_q <= S_SIDE;
					end
				end
				S_SIDE: begin
					first_q <= 1'b0;
					if (n_done) begin
						if (!nsel_q) begin
							side_q[0] <= n_ox; side_q[1] <= n_oy; side_q[2] <= n_oz;
							nsel_q <= 1'b1; first_q <= 1'b1;
						end else begin
							upv_q[0] <= n_ox; upv_q[1] <= n_oy; upv_q[2] <= n_oz;
							st_q <= S_NU;
						end
					end
				end
				S_NU: begin
					// first pass after reset produces no response
					st_q <= S_RSP;
				end
				S_MUL: begin
					// walk the held keys in bit order, one component a cycle
					if (!keys_q[key_q]) begin
						if (key_q == 3'd5) st_q <= S_MOVE;
						else key_q <= key_q + 1'b1;
					end else begin
						pos_q[k_q] <= (psum > 34'sd2147483647) ? 32'sh7FFFFFFF :
							((psum < -34'sd2147483648) ? 32'sh80000000 : psum[31:0]);
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (key_q == 3'd5) st_q <= S_MOVE;
							else key_q <= key_q + 1'b1;
						end else k_q <= k_q + 1'b1;
					end
				end
				S_MOVE: st_q <= S_RSP;
				S_RSP: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q <= '{pos_q[0], pos_q[1], pos_q[2], fwd_q[0], fwd_q[1], fwd_q[2],
							side_q[0], side_q[1], side_q[2], upv_q[0], upv_q[1], upv_q[2]};
						rsp_valid_q <= pend_q;
						pend_q <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/ypcb_checker.sv
module ypcb_checker import ypcb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(rsp_data)) else $error("response changed");
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
endmodule

bind yaw_pitch_camera_basis_top ypcb_checker u_chk (.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

### sim/yaw_pitch_camera_basis_top_tb.sv
`timescale 1ns / 100ps

module yaw_pitch_camera_basis_top_tb;
	import ypcb_pkg::*;

	localparam int RUN_LIMIT = 3000000;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_PHASES = 8;
	localparam logic [2:0] RegUnused = 3'd7;

	typedef longint vec3_t [3];

	// one row of the directed stimulus; at_origin marks rows where the position
	// must read back as the origin
	typedef struct {
		logic        op;
		logic [5:0]  keys;
		logic [15:0] dt;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		bit          at_origin;
	} row_t;

	typedef struct {
		rsp_t pose;
		bit   at_origin;
	} pose_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	ypcb_req_if req_ch ();
	ypcb_rsp_if rsp_ch ();

	yaw_pitch_camera_basis_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Camera model: registers, pose and basis kept alongside the block
	// ------------------------------------------------------------------
	logic [15:0]        cam_move_speed;
	logic [15:0]        cam_turn_speed;
	logic signed [15:0] cam_world_up [3];
	vec3_t              cam_pos;
	longint             cam_yaw;
	longint             cam_pitch;
	vec3_t              cam_front, cam_right, cam_up;

	pose_exp_t pose_queue[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        hold_rsp = 1'b0;
	bit        start_hold_off = 1'b0;

	// arctan(2^-i) in 2^-16 degree
	localparam longint ArcTab [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint wrap_heading(input longint v);
		longint r;
		r = (v + 23040) % 46080;
		if (r < 0) r += 46080;
		return r - 23040;
	endfunction

	function automatic longint clamp_elevation(input longint v);
		if (v >= 11392) return 11392;
		if (v <= -11392) return -11392;
		return v;
	endfunction

	// rotate a unit vector by ang (1/128 degree); results carry the CORDIC gain, Q30
	function automatic void rotate_unit(input longint ang, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = ang * 512;
		x = 64'sd1073741824;
		y = 0;
		flip = 1'b0;
		if (z > 5898240) begin
			z -= 11796480;
			flip = 1'b1;
		end else if (z < -5898240) begin
			z += 11796480;
			flip = 1'b1;
		end
		for (int i = 0; i < CordicSteps && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ArcTab[i];
			end else begin
				x += dx;
				y -= dy;
				z += ArcTab[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void unit_length(input vec3_t v, output vec3_t o);
		longint unsigned mag [3];
		longint unsigned len2, len, q;
		longint sq;
		len2 = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
			len2 += mag[k] * mag[k];
		end
		len = int_sqrt(len2);
		for (int k = 0; k < 3; k++) begin
			if (len == 0) begin
				o[k] = 0;
			end else begin
				q = ((mag[k] << VecFracBits) + len / 2) / len;
				sq = longint'(q);
				if (sq > 32767) sq = 32767;
				if (v[k] < 0) sq = -sq;
				if (sq < -32768) sq = -32768;
				o[k] = sq;
			end
		end
	endfunction

	function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t r);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic void rebuild_camera_basis();
		longint g, gs, cy, sy, cp, sp;
		vec3_t raw, wup;
		rotate_unit(0, g, gs);
		rotate_unit(cam_yaw, cy, sy);
		rotate_unit(cam_pitch, cp, sp);
		raw[0] = (cy * cp) >>> 32;
		raw[1] = (sp * g) >>> 32;
		raw[2] = (sy * cp) >>> 32;
		unit_length(raw, cam_front);
		for (int k = 0; k < 3; k++) wup[k] = cam_world_up[k];
		cross_prod(cam_front, wup, raw);
		unit_length(raw, cam_right);
		cross_prod(cam_right, cam_front, raw);
		unit_length(raw, cam_up);
	endfunction

	function automatic void nudge_position(input vec3_t dir, input longint vel, input bit minus);
		longint d, p;
		for (int k = 0; k < 3; k++) begin
			d = (dir[k] * vel + (64'sd1 <<< (VecFracBits + 7))) >>> (VecFracBits + 8);
			p = cam_pos[k] + (minus ? -d : d);
			if (p > 64'sd2147483647) p = 64'sd2147483647;
			if (p < -64'sd2147483648) p = -64'sd2147483648;
			cam_pos[k] = p;
		end
	endfunction

	function automatic void reset_camera();
		cam_move_speed = 16'd1280;
		cam_turn_speed = 16'd4096;
		cam_world_up[0] = 16'sd0;
		cam_world_up[1] = 16'sd16384;
		cam_world_up[2] = 16'sd0;
		for (int k = 0; k < 3; k++) cam_pos[k] = 0;
		cam_yaw = wrap_heading(-11520);
		cam_pitch = clamp_elevation(0);
		rebuild_camera_basis();
	endfunction

	// advance the camera by one request and return the pose it reports
	function automatic rsp_t step_camera(input req_t item);
		longint vel;
		vec3_t wup;
		rsp_t r;
		if (item.op == OpTurn) begin
			cam_yaw = wrap_heading(cam_yaw +
				((longint'(item.turn_x) * longint'(cam_turn_speed) + 16) >>> 5));
			cam_pitch = clamp_elevation(cam_pitch +
				((longint'(item.turn_y) * longint'(cam_turn_speed) + 16) >>> 5));
			rebuild_camera_basis();
		end else begin
			vel = longint'(cam_move_speed) * longint'(item.delta_time);
			for (int k = 0; k < 3; k++) wup[k] = cam_world_up[k];
			if (item.key_mask[0]) nudge_position(cam_front, vel, 1'b0);
			if (item.key_mask[1]) nudge_position(cam_front, vel, 1'b1);
			if (item.key_mask[2]) nudge_position(cam_right, vel, 1'b1);
			if (item.key_mask[3]) nudge_position(cam_right, vel, 1'b0);
			if (item.key_mask[4]) nudge_position(wup, vel, 1'b0);
			if (item.key_mask[5]) nudge_position(wup, vel, 1'b1);
		end
		r.pos_x = cam_pos[0][31:0];
		r.pos_y = cam_pos[1][31:0];
		r.pos_z = cam_pos[2][31:0];
		r.fwd_x = cam_front[0][15:0];
		r.fwd_y = cam_front[1][15:0];
		r.fwd_z = cam_front[2][15:0];
		r.side_x = cam_right[0][15:0];
		r.side_y = cam_right[1][15:0];
		r.side_z = cam_right[2][15:0];
		r.upward_x = cam_up[0][15:0];
		r.upward_y = cam_up[1][15:0];
		r.upward_z = cam_up[2][15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Pose checker: compare every accepted result with the oldest prediction
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		pose_exp_t e;
		rsp_t a;
		if (rsp_ch.valid && rsp_ch.ready) begin
			a = rsp_ch.data;
			if (pose_queue.size() == 0) begin
				fail_count++;
				$display("%0t: pose returned with none pending, expected none, actual %h",
					$time, a);
			end else begin
				e = pose_queue.pop_front();
				// pinned rows: position must be back at the origin
				if (e.at_origin) begin
					check_field("origin pos_x", 0, a.pos_x);
					check_field("origin pos_y", 0, a.pos_y);
					check_field("origin pos_z", 0, a.pos_z);
				end
				check_field("pos_x", e.pose.pos_x, a.pos_x);
				check_field("pos_y", e.pose.pos_y, a.pos_y);
				check_field("pos_z", e.pose.pos_z, a.pos_z);
				check_field("fwd_x", e.pose.fwd_x, a.fwd_x);
				check_field("fwd_y", e.pose.fwd_y, a.fwd_y);
				check_field("fwd_z", e.pose.fwd_z, a.fwd_z);
				check_field("side_x", e.pose.side_x, a.side_x);
				check_field("side_y", e.pose.side_y, a.side_y);
				check_field("side_z", e.pose.side_z, a.side_z);
				check_field("upward_x", e.pose.upward_x, a.upward_x);
				check_field("upward_y", e.pose.upward_y, a.upward_y);
				check_field("upward_z", e.pose.upward_z, a.upward_z);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side back-pressure: a randomly chosen stall pattern that changes
	// periodically, plus one long hold-off while requests keep coming
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int stall_age = 0;

	always @(negedge clk) begin
		if (stall_age >= 250) begin
			stall_age <= 0;
			stall_mode <= $urandom_range(0, 3);
		end else begin
			stall_age <= stall_age + 1;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ch.ready = 1'b0;
			end else begin
				case (stall_mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = ($urandom_range(0, 1) == 1);
					2: rsp_ch.ready = ($urandom_range(0, 5) == 0);
					default: rsp_ch.ready = (stall_age[3:0] < 4'd3);
				endcase
			end
		end
	end

	initial begin
		wait (start_hold_off);
		hold_rsp = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_rsp = 1'b0;
	end

	// give up if the run stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// present a request from a falling edge; leave valid high on return so a
	// back-to-back request keeps it asserted
	task automatic offer_request(input req_t item, input bit at_origin);
		pose_exp_t e;
		req_ch.valid = 1'b1;
		req_ch.data = item;
		do @(posedge clk); while (!req_ch.ready);
		e.pose = step_camera(item);
		e.at_origin = at_origin;
		pose_queue.push_back(e);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			RegMoveSpeed: cam_move_speed = value;
			RegTurnSpeed: cam_turn_speed = value;
			RegUpX:       cam_world_up[0] = value;
			RegUpY:       cam_world_up[1] = value;
			RegUpZ:       cam_world_up[2] = value;
			// start angle writes are ignored by the block; reset is never repeated
			default: ;
		endcase
	endtask

	// drain outstanding poses before touching the registers
	task automatic wait_idle();
		req_ch.valid = 1'b0;
		while (pose_queue.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic load_settings(input int phase);
		case (phase)
			1: begin
				write_reg(RegMoveSpeed, 16'hFFFF);
				write_reg(RegTurnSpeed, 16'hFFFF);
			end
			2: begin
				write_reg(RegMoveSpeed, 16'd0);
				write_reg(RegTurnSpeed, 16'd0);
			end
			3: begin
				// zero world up: right and up collapse to zero at the next turn
				write_reg(RegMoveSpeed, 16'd1280);
				write_reg(RegTurnSpeed, 16'd4096);
				write_reg(RegUpX, 16'd0);
				write_reg(RegUpY, 16'd0);
				write_reg(RegUpZ, 16'd0);
			end
			4: begin
				write_reg(RegUpX, -16'sd16384);
				write_reg(RegTurnSpeed, 16'd1);
				write_reg(RegMoveSpeed, 16'd255);
			end
			5: begin
				write_reg(RegUpX, 16'sd16384);
				write_reg(RegUpY, 16'sd16384);
				write_reg(RegUpZ, 16'sd16384);
				write_reg(RegTurnSpeed, 16'd4096);
				write_reg(RegMoveSpeed, 16'd1280);
				write_reg(RegStartYaw, 16'sd23039);
				write_reg(RegStartPitch, 16'h7FFF & (-16'sd11392));
				write_reg(RegUnused, 16'hFFFF);
			end
			6: begin
				write_reg(RegUpX, 16'sd0);
				write_reg(RegUpY, -16'sd16384);
				write_reg(RegUpZ, 16'sd0);
				write_reg(RegMoveSpeed, 16'hFFFF);
				write_reg(RegStartYaw, -16'sd23040);
				write_reg(RegStartPitch, 16'd11392);
			end
			default: begin
				write_reg(RegMoveSpeed, 16'($urandom));
				write_reg(RegTurnSpeed, 16'($urandom_range(0, 16384)));
				write_reg(RegUpX, 16'($urandom_range(0, 32768) - 16384));
				write_reg(RegUpY, 16'($urandom_range(0, 32768) - 16384));
				write_reg(RegUpZ, 16'($urandom_range(0, 32768) - 16384));
			end
		endcase
	endtask

	function automatic req_t random_request();
		req_t item;
		item.op = ($urandom_range(0, 9) < 4) ? OpTurn : OpMove;
		item.key_mask = 6'($urandom);
		item.delta_time = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 2000));
		// mostly gentle mouse moves so the pitch is not always pinned to a limit
		if ($urandom_range(0, 4) == 0) begin
			item.turn_x = 16'($urandom);
			item.turn_y = 16'($urandom);
		end else begin
			item.turn_x = 16'($urandom_range(0, 400) - 200);
			item.turn_y = 16'($urandom_range(0, 400) - 200);
		end
		return item;
	endfunction

	// Directed rows: empty move, forward then back (cancels), opposing key pairs
	// (cancel), ignored fields on both ops, both pitch limits and the yaw wrap.
	row_t directed [18] = '{
		'{OpMove, 6'h00, 16'h0000, 16'sh0000, 16'sh0000, 1'b1},
		'{OpMove, 6'h01, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0},
		'{OpMove, 6'h02, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b1},
		'{OpMove, 6'h3F, 16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1},
		'{OpMove, 6'h04, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0},
		'{OpMove, 6'h08, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b1},
		'{OpMove, 6'h10, 16'h8000, 16'sh0000, 16'sh0000, 1'b0},
		'{OpMove, 6'h20, 16'h8000, 16'sh0000, 16'sh0000, 1'b1},
		'{OpTurn, 6'h3F, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b1},
		'{OpTurn, 6'h00, 16'h0000, 16'sh7FFF, 16'sh7FFF, 1'b1},
		'{OpTurn, 6'h00, 16'h0000, 16'sh0000, 16'sh7FFF, 1'b1},
		'{OpTurn, 6'h00, 16'h0000, 16'sh8000, 16'sh8000, 1'b1},
		'{OpTurn, 6'h00, 16'h0000, 16'sh8000, 16'sh0000, 1'b1},
		'{OpTurn, 6'h00, 16'h0000, 16'sh0001, 16'shFFFF, 1'b1},
		'{OpMove, 6'h09, 16'h0001, 16'sh0000, 16'sh0000, 1'b0},
		'{OpMove, 6'h15, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0},
		'{OpTurn, 6'h00, 16'h0000, 16'sh0100, 16'shFF00, 1'b0},
		'{OpMove, 6'h2A, 16'hFFFF, 16'sh0000, 16'sh0000, 1'b0}
	};

	initial begin
		req_t item;
		int burst_left;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		reset_camera();

		// hold reset, then release it on a falling edge
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			item.op = directed[i].op;
			item.key_mask = directed[i].keys;
			item.delta_time = directed[i].dt;
			item.turn_x = directed[i].tx;
			item.turn_y = directed[i].ty;
			offer_request(item, directed[i].at_origin);
		end

		burst_left = 0;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase != 0) begin
				wait_idle();
				load_settings(phase);
			end
			if (phase == 1) start_hold_off = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// bursts of back-to-back requests, most separated by random gaps
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if ($urandom_range(0, 2) != 0) begin
						req_ch.valid = 1'b0;
						repeat ($urandom_range(1, 40)) @(negedge clk);
					end
				end
				burst_left--;
				offer_request(random_request(), 1'b0);
			end
		end

		req_ch.valid = 1'b0;
		while (pose_queue.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
